FILE: hdl/marching_squares_cell_contour_core_assert.svh
// Assertion macros for the marching-squares contour core checker.
`ifndef MARCHING_SQUARES_CELL_CONTOUR_CORE_ASSERT_SVH
`define MARCHING_SQUARES_CELL_CONTOUR_CORE_ASSERT_SVH

// Clocked assertion, suspended while reset is asserted.
`define MSCC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also runs across reset.
`define MSCC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mscc_pkg.sv
// Shared types, constants and lookup tables for the contour cell core.
package mscc_pkg;

	localparam int GRID_SIZE  = 1024;
	localparam int CELL_W     = 10;
	localparam int VAL_W      = 32;
	localparam int STEP_W     = 31;
	localparam int FRAC_BITS  = 16;
	localparam int T_W        = FRAC_BITS + 1;
	localparam int DIV_LAT    = FRAC_BITS + 1;
	localparam int PROD_W     = T_W + STEP_W;
	localparam int GEO_W      = CELL_W + STEP_W;
	localparam int COORD_W    = GEO_W + 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W  = 3;

	localparam logic [T_W-1:0] T_HALF = T_W'(1) << (FRAC_BITS - 1);
	localparam logic [T_W-1:0] T_ONE  = T_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0] T_ZERO = '0;

	localparam logic [3:0] CASE_EMPTY   = 4'd0;
	localparam logic [3:0] CASE_FULL    = 4'd15;
	localparam logic [3:0] CASE_SADDLE_A = 4'd5;
	localparam logic [3:0] CASE_SADDLE_B = 4'd10;
	localparam logic [3:0] MASK_ALL     = 4'hF;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd4;

	// edge pairs per case: {seg0 first, seg0 second, seg1 first, seg1 second}
	localparam logic [1:0] SEG_EDGES [16][4] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd3, 2'd0, 2'd0, 2'd0},
		'{2'd0, 2'd1, 2'd0, 2'd0}, '{2'd3, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd2, 2'd0, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd1},
		'{2'd0, 2'd2, 2'd0, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd0},
		'{2'd2, 2'd3, 2'd0, 2'd0}, '{2'd0, 2'd2, 2'd0, 2'd0},
		'{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd0},
		'{2'd3, 2'd1, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0, 2'd0},
		'{2'd3, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0}
	};

	typedef struct packed {
		logic signed [VAL_W-1:0]  level;
		logic signed [VAL_W-1:0]  x_origin;
		logic signed [VAL_W-1:0]  y_top;
		logic        [STEP_W-1:0] step_x;
		logic        [STEP_W-1:0] step_y;
	} cfg_t;

	// one classified cell waiting for the back end
	typedef struct packed {
		logic [CELL_W-1:0]       row;
		logic [CELL_W-1:0]       col;
		logic [3:0]              cs;
		logic signed [VAL_W-1:0] tl;
		logic signed [VAL_W-1:0] tr;
		logic signed [VAL_W-1:0] br;
		logic signed [VAL_W-1:0] bl;
	} entry_t;

	// per-segment control traveling with the datapath
	typedef struct packed {
		logic [CELL_W-1:0] row;
		logic [CELL_W-1:0] col;
		logic [1:0]        e0;
		logic [1:0]        e1;
		logic              last;
	} side_t;

	function automatic logic is_saddle(input logic [3:0] cs);
		return (cs == CASE_SADDLE_A) || (cs == CASE_SADDLE_B);
	endfunction

endpackage

FILE: hdl/mscc_front.sv
// Front end: classifies an incoming cell and decides whether it yields segments.
module mscc_front (
	input  logic                           start,
	input  logic                           busy,
	input  mscc_pkg::cfg_t                 cfg,
	input  logic [mscc_pkg::CELL_W-1:0]    cell_row,
	input  logic [mscc_pkg::CELL_W-1:0]    cell_column,
	input  logic signed [mscc_pkg::VAL_W-1:0] corner_top_left,
	input  logic signed [mscc_pkg::VAL_W-1:0] corner_top_right,
	input  logic signed [mscc_pkg::VAL_W-1:0] corner_bottom_right,
	input  logic signed [mscc_pkg::VAL_W-1:0] corner_bottom_left,
	input  logic [3:0]                     finite_mask,
	output logic                           push,
	output mscc_pkg::entry_t               entry
);
	import mscc_pkg::*;

	localparam int LIM_W = CELL_W + 2;
	localparam logic [LIM_W-1:0] CELL_MAX = LIM_W'(GRID_SIZE - 2);

	logic [3:0] cs;
	logic       in_grid;

	always_comb begin
		cs[0] = corner_top_left     >= cfg.level;
		cs[1] = corner_top_right    >= cfg.level;
		cs[2] = corner_bottom_right >= cfg.level;
		cs[3] = corner_bottom_left  >= cfg.level;
	end

	assign in_grid = (LIM_W'(cell_row) <= CELL_MAX) && (LIM_W'(cell_column) <= CELL_MAX);

	// drop non-finite, off-grid and flat cells right here
	assign push = start && !busy && (finite_mask == MASK_ALL) && in_grid
		&& (cs != CASE_EMPTY) && (cs != CASE_FULL);

	always_comb begin
		entry.row = cell_row;
		entry.col = cell_column;
		entry.cs  = cs;
		entry.tl  = corner_top_left;
		entry.tr  = corner_top_right;
		entry.br  = corner_bottom_right;
		entry.bl  = corner_bottom_left;
	end

endmodule

FILE: hdl/mscc_fifo.sv
// Short queue of classified cells between front and back end.
module mscc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mscc_pkg::entry_t wdata,
	input  logic             pop,
	output mscc_pkg::entry_t rdata,
	output logic             empty,
	output logic             full
);
	import mscc_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/mscc_div.sv
// Pipelined restoring divider for the edge fraction, one quotient bit per stage.
module mscc_div (
	input  logic                          clk,
	input  logic [mscc_pkg::VAL_W-1:0]    num,
	input  logic [mscc_pkg::VAL_W-1:0]    den,
	input  logic                          fix,
	input  logic [mscc_pkg::T_W-1:0]      t_fix,
	output logic [mscc_pkg::T_W-1:0]      t
);
	import mscc_pkg::*;

	logic [VAL_W-1:0]     rem_s  [FRAC_BITS+1];
	logic [VAL_W-1:0]     den_s  [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] quo_s  [FRAC_BITS+1];
	logic                 fix_s  [FRAC_BITS+1];
	logic [T_W-1:0]       tfix_s [FRAC_BITS+1];

	always_ff @(posedge clk) begin
		rem_s[0]  <= num;
		den_s[0]  <= den;
		quo_s[0]  <= '0;
		fix_s[0]  <= fix;
		tfix_s[0] <= t_fix;
	end

	for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
		logic [VAL_W:0] dbl;
		logic           ge;
		assign dbl = {rem_s[i-1], 1'b0};
		assign ge  = dbl >= {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? VAL_W'(dbl - {1'b0, den_s[i-1]}) : VAL_W'(dbl);
			den_s[i]  <= den_s[i-1];
			quo_s[i]  <= {quo_s[i-1][FRAC_BITS-2:0], ge};
			fix_s[i]  <= fix_s[i-1];
			tfix_s[i] <= tfix_s[i-1];
		end
	end

	assign t = fix_s[FRAC_BITS] ? tfix_s[FRAC_BITS] : {1'b0, quo_s[FRAC_BITS]};

endmodule

FILE: hdl/mscc_back.sv
// Back end: issues segments from the queue, interpolates endpoints, drives results.
module mscc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mscc_pkg::cfg_t                    cfg,
	input  mscc_pkg::entry_t                  head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              strobe,
	output logic signed [mscc_pkg::VAL_W-1:0] start_x,
	output logic signed [mscc_pkg::VAL_W-1:0] start_y,
	output logic signed [mscc_pkg::VAL_W-1:0] end_x,
	output logic signed [mscc_pkg::VAL_W-1:0] end_y,
	output logic                              last_segment
);
	import mscc_pkg::*;

	localparam int D_W = VAL_W + 1;

	function automatic logic signed [VAL_W-1:0] corner_at(input entry_t e, input logic [1:0] i);
		logic signed [VAL_W-1:0] v;
		case (i)
			2'd0:    v = e.tl;
			2'd1:    v = e.tr;
			2'd2:    v = e.br;
			default: v = e.bl;
		endcase
		return v;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat(input logic signed [COORD_W-1:0] v);
		logic signed [COORD_W-1:0] hi;
		logic signed [COORD_W-1:0] lo;
		hi = COORD_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
		lo = -hi - COORD_W'(1);
		if (v > hi) begin
			return {1'b0, {(VAL_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(VAL_W-1){1'b0}}};
		end
		return VAL_W'(v);
	endfunction

	// endpoint on edge e; edges 0..3 run top, right, bottom, left
	function automatic void edge_point(
		input  logic [1:0]                e,
		input  logic signed [COORD_W-1:0] left,
		input  logic signed [COORD_W-1:0] top,
		input  logic [VAL_W-1:0]          off,
		input  cfg_t                      c,
		output logic signed [VAL_W-1:0]   px,
		output logic signed [VAL_W-1:0]   py
	);
		logic signed [COORD_W-1:0] o;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		o  = COORD_W'(off);
		sx = COORD_W'(c.step_x);
		sy = COORD_W'(c.step_y);
		case (e)
			2'd0: begin
				px = sat(left + o);
				py = sat(top);
			end
			2'd1: begin
				px = sat(left + sx);
				py = sat(top - o);
			end
			2'd2: begin
				px = sat(left + sx - o);
				py = sat(top - sy);
			end
			default: begin
				px = sat(left);
				py = sat(top - sy + o);
			end
		endcase
	endfunction

	// issue
	logic       sel_q;
	logic       saddle;
	logic       issue;
	side_t      side_i;
	logic [1:0] edge_i [2];

	assign saddle = is_saddle(head.cs);
	assign issue  = !empty;
	assign pop    = issue && (!saddle || sel_q);

	always_comb begin
		edge_i[0]   = SEG_EDGES[head.cs][{sel_q, 1'b0}];
		edge_i[1]   = SEG_EDGES[head.cs][{sel_q, 1'b1}];
		side_i.row  = head.row;
		side_i.col  = head.col;
		side_i.e0   = edge_i[0];
		side_i.e1   = edge_i[1];
		side_i.last = !saddle || sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else begin
			sel_q <= issue && saddle && !sel_q;
		end
	end

	// s1: differences, s2: sign fold
	logic                    v_s1, v_s2;
	side_t                   side_s1, side_s2;
	logic signed [D_W-1:0]   d_s1 [2];
	logic signed [D_W-1:0]   n_s1 [2];
	logic [VAL_W-1:0]        dabs_s2 [2];
	logic signed [D_W-1:0]   n_s2 [2];
	logic [T_W-1:0]          t_lane [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_i;
		side_s2 <= side_s1;
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [VAL_W-1:0] va;
		logic signed [VAL_W-1:0] vb;
		logic                    fix;
		logic [T_W-1:0]          t_fix;

		assign va = corner_at(head, edge_i[l]);
		assign vb = corner_at(head, edge_i[l] + 2'd1);

		always_ff @(posedge clk) begin
			d_s1[l]    <= D_W'(vb) - D_W'(va);
			n_s1[l]    <= D_W'(cfg.level) - D_W'(va);
			dabs_s2[l] <= d_s1[l][D_W-1] ? VAL_W'(-d_s1[l]) : VAL_W'(d_s1[l]);
			n_s2[l]    <= d_s1[l][D_W-1] ? -n_s1[l] : n_s1[l];
		end

		// pinned fractions: flat edge, level at or beyond either end
		always_comb begin
			fix   = 1'b1;
			t_fix = T_ZERO;
			if (dabs_s2[l] == '0) begin
				t_fix = T_HALF;
			end else if (n_s2[l][D_W-1] || n_s2[l] == '0) begin
				t_fix = T_ZERO;
			end else if (n_s2[l] >= D_W'(dabs_s2[l])) begin
				t_fix = T_ONE;
			end else begin
				fix = 1'b0;
			end
		end

		mscc_div u_div (
			.clk   (clk),
			.num   (VAL_W'(n_s2[l])),
			.den   (dabs_s2[l]),
			.fix   (fix),
			.t_fix (t_fix),
			.t     (t_lane[l])
		);
	end

	// side info delay matching the divider
	logic  v_d_q    [DIV_LAT];
	side_t side_d_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				v_d_q[i] <= 1'b0;
			end
		end else begin
			v_d_q[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_d_q[i] <= v_d_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_d_q[0] <= side_s2;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_d_q[i] <= side_d_q[i-1];
		end
	end

	// s3: products, s4: offsets and cell corner
	logic                       v_s3, v_s4;
	side_t                      side_s3, side_s4;
	logic [PROD_W-1:0]          prod_s3 [2];
	logic [GEO_W-1:0]           colx_s3, rowy_s3;
	logic [VAL_W-1:0]           off_s4 [2];
	logic signed [COORD_W-1:0]  left_s4, top_s4;
	side_t                      side_t3;
	logic [1:0]                 e_t3 [2];

	assign side_t3 = side_d_q[DIV_LAT-1];
	assign e_t3[0] = side_t3.e0;
	assign e_t3[1] = side_t3.e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_d_q[DIV_LAT-1];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_t3;
		side_s4 <= side_s3;
		colx_s3 <= GEO_W'(side_t3.col) * GEO_W'(cfg.step_x);
		rowy_s3 <= GEO_W'(side_t3.row) * GEO_W'(cfg.step_y);
		for (int l = 0; l < 2; l++) begin
			// x-moving edges (top, bottom) scale by step_x, the others by step_y
			prod_s3[l] <= PROD_W'(t_lane[l])
				* PROD_W'(e_t3[l][0] ? cfg.step_y : cfg.step_x);
			off_s4[l]  <= VAL_W'((prod_s3[l] + PROD_W'(T_HALF)) >> FRAC_BITS);
		end
		left_s4 <= COORD_W'(cfg.x_origin) + COORD_W'(colx_s3);
		top_s4  <= COORD_W'(cfg.y_top) - COORD_W'(rowy_s3);
	end

	// output register
	logic                    strobe_q;
	logic                    last_q;
	logic signed [VAL_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [VAL_W-1:0] sx_c, sy_c, ex_c, ey_c;

	always_comb begin
		edge_point(side_s4.e0, left_s4, top_s4, off_s4[0], cfg, sx_c, sy_c);
		edge_point(side_s4.e1, left_s4, top_s4, off_s4[1], cfg, ex_c, ey_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sx_q   <= sx_c;
		sy_q   <= sy_c;
		ex_q   <= ex_c;
		ey_q   <= ey_c;
		last_q <= side_s4.last;
	end

	assign strobe       = strobe_q;
	assign start_x      = sx_q;
	assign start_y      = sy_q;
	assign end_x        = ex_q;
	assign end_y        = ey_q;
	assign last_segment = last_q;

endmodule

FILE: hdl/marching_squares_cell_contour_core.sv
// Top level of the marching-squares contour cell core.
//
// Usage: one cell is taken per clock whenever busy is low (start high and busy
// low is a transfer). Cells with a non-finite corner, outside the grid, or
// with a flat case produce nothing. Every other cell yields one segment, the
// saddle cases two, each shown for a single cycle with strobe high and
// last_segment marking the final segment of the cell. The result side has no
// back-pressure: the receiver must take every strobe. The two segments of a
// saddle come on consecutive cycles. Throughput is one segment per clock, set
// by the single issue port of the back end: plain cells stream at one per
// clock, a saddle holds the issue port for both of its segments. A four-entry
// queue sits between the classifying front end and the back end; busy is high
// while it is full. Configuration writes (cfg_valid, always ready) are meant
// for idle times.
module marching_squares_cell_contour_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// cell input
	input  logic                                start,
	output logic                                busy,
	input  logic [mscc_pkg::CELL_W-1:0]         cell_row,
	input  logic [mscc_pkg::CELL_W-1:0]         cell_column,
	input  logic signed [mscc_pkg::VAL_W-1:0]   corner_top_left,
	input  logic signed [mscc_pkg::VAL_W-1:0]   corner_top_right,
	input  logic signed [mscc_pkg::VAL_W-1:0]   corner_bottom_right,
	input  logic signed [mscc_pkg::VAL_W-1:0]   corner_bottom_left,
	input  logic [3:0]                          finite_mask,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mscc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mscc_pkg::VAL_W-1:0]          cfg_data,
	// segment results
	output logic                                strobe,
	output logic signed [mscc_pkg::VAL_W-1:0]   start_x,
	output logic signed [mscc_pkg::VAL_W-1:0]   start_y,
	output logic signed [mscc_pkg::VAL_W-1:0]   end_x,
	output logic signed [mscc_pkg::VAL_W-1:0]   end_y,
	output logic                                last_segment
);
	import mscc_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	logic   pop;
	logic   empty;
	logic   full;
	entry_t entry_in;
	entry_t entry_head;

	// register file; unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level    <= '0;
			cfg_q.x_origin <= '0;
			cfg_q.y_top    <= '0;
			cfg_q.step_x   <= STEP_W'(65536);
			cfg_q.step_y   <= STEP_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEVEL:    cfg_q.level    <= cfg_data;
				REG_X_ORIGIN: cfg_q.x_origin <= cfg_data;
				REG_Y_TOP:    cfg_q.y_top    <= cfg_data;
				REG_STEP_X:   cfg_q.step_x   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:   cfg_q.step_y   <= cfg_data[STEP_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// the queue alone throttles the input
	assign busy = full;

	mscc_front u_front (
		.start               (start),
		.busy                (busy),
		.cfg                 (cfg_q),
		.cell_row            (cell_row),
		.cell_column         (cell_column),
		.corner_top_left     (corner_top_left),
		.corner_top_right    (corner_top_right),
		.corner_bottom_right (corner_bottom_right),
		.corner_bottom_left  (corner_bottom_left),
		.finite_mask         (finite_mask),
		.push                (push),
		.entry               (entry_in)
	);

	mscc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry_in),
		.pop    (pop),
		.rdata  (entry_head),
		.empty  (empty),
		.full   (full)
	);

	mscc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (entry_head),
		.empty        (empty),
		.pop          (pop),
		.strobe       (strobe),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.last_segment (last_segment)
	);

endmodule

FILE: hdl/mscc_checker.sv
// Port-level checker for the contour cell core, bound to the top level.
`include "marching_squares_cell_contour_core_assert.svh"

module mscc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                busy,
	input logic                                strobe,
	input logic                                last_segment
);

	// first segment of a saddle is always followed by its partner
	`MSCC_ASSERT(a_saddle_pair, strobe && !last_segment |=> strobe && last_segment, "saddle segment without partner")

	// no results and no backpressure right out of reset
	`MSCC_ASSERT_ALWAYS(a_reset_quiet, $rose(arst_n) |-> !strobe && !busy, "activity right after reset")

	// the pipeline cannot produce a result the cycle after leaving reset either
	`MSCC_ASSERT(a_reset_latency, $rose(arst_n) |=> !strobe, "result too early after reset")

endmodule

bind marching_squares_cell_contour_core mscc_checker u_mscc_checker (.*);

FILE: bench/mscc_segment_checker.sv
// Segment checker: snoops the ports, predicts each cell's segments and compares.
`timescale 1ns / 100ps
module mscc_segment_checker
	import mscc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [CELL_W-1:0]        cell_row,
	input  logic [CELL_W-1:0]        cell_column,
	input  logic signed [VAL_W-1:0]  corner_top_left,
	input  logic signed [VAL_W-1:0]  corner_top_right,
	input  logic signed [VAL_W-1:0]  corner_bottom_right,
	input  logic signed [VAL_W-1:0]  corner_bottom_left,
	input  logic [3:0]               finite_mask,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [VAL_W-1:0]         cfg_data,
	input  logic                     strobe,
	input  logic signed [VAL_W-1:0]  start_x,
	input  logic signed [VAL_W-1:0]  start_y,
	input  logic signed [VAL_W-1:0]  end_x,
	input  logic signed [VAL_W-1:0]  end_y,
	input  logic                     last_segment,
	output int                       failures,
	output int                       pending
);

	typedef struct {
		logic [VAL_W-1:0] sx, sy, ex, ey;
		logic             last;
	} segment_t;

	segment_t seg_q[$];

	longint lvl, x0, y0, dx, dy;

	assign pending = seg_q.size();

	// position along an edge: fraction of va..vb where level sits, times delta
	function automatic longint edge_shift(longint va, longint vb, longint delta);
		longint d, n, t, mag, ad;
		d = vb - va;
		n = lvl - va;
		if (d == 0) begin
			t = 32768;
		end else begin
			if (d < 0) begin
				d = -d;
				n = -n;
			end
			if (n <= 0) t = 0;
			else if (n >= d) t = 65536;
			else t = (n <<< 16) / d;
		end
		ad = (delta < 0) ? -delta : delta;
		mag = (t * ad + 32768) >>> 16;
		return (delta < 0) ? -mag : mag;
	endfunction

	function automatic logic [VAL_W-1:0] clip32(longint v);
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return v[VAL_W-1:0];
	endfunction

	task automatic predict_cell();
		longint v[4], px[4], py[4], ex[4], ey[4];
		longint lft, top;
		logic [3:0] cs;
		int cnt, a, b, e0, e1;
		segment_t s;
		if (finite_mask != MASK_ALL) return;
		if (cell_row > GRID_SIZE - 2 || cell_column > GRID_SIZE - 2) return;
		v[0] = corner_top_left;
		v[1] = corner_top_right;
		v[2] = corner_bottom_right;
		v[3] = corner_bottom_left;
		for (int i = 0; i < 4; i++) cs[i] = (v[i] >= lvl);
		if (cs == CASE_EMPTY || cs == CASE_FULL) return;
		cnt = (cs == CASE_SADDLE_A || cs == CASE_SADDLE_B) ? 2 : 1;
		lft = x0 + longint'(cell_column) * dx;
		top = y0 - longint'(cell_row) * dy;
		px[0] = lft;      py[0] = top;
		px[1] = lft + dx; py[1] = top;
		px[2] = lft + dx; py[2] = top - dy;
		px[3] = lft;      py[3] = top - dy;
		// edge i runs from corner i to corner i+1
		for (int i = 0; i < 4; i++) begin
			a = i;
			b = (i + 1) % 4;
			ex[i] = px[a] + edge_shift(v[a], v[b], px[b] - px[a]);
			ey[i] = py[a] + edge_shift(v[a], v[b], py[b] - py[a]);
		end
		for (int k = 0; k < cnt; k++) begin
			e0 = SEG_EDGES[cs][2*k];
			e1 = SEG_EDGES[cs][2*k+1];
			s.sx = clip32(ex[e0]);
			s.sy = clip32(ey[e0]);
			s.ex = clip32(ex[e1]);
			s.ey = clip32(ey[e1]);
			s.last = (k == cnt - 1);
			seg_q.push_back(s);
		end
	endtask

	task automatic compare_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act);
		if (exp_v !== act) begin
			$error("%s: expected %h, got %h", name, exp_v, act);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl = 0;
			x0 = 0;
			y0 = 0;
			dx = 65536;
			dy = 65536;
			seg_q.delete();
		end else begin
			if (strobe) begin
				if (seg_q.size() == 0) begin
					$error("segment with nothing expected: %h %h %h %h",
						start_x, start_y, end_x, end_y);
					failures++;
				end else begin
					segment_t s;
					s = seg_q.pop_front();
					compare_field("start_x", s.sx, start_x);
					compare_field("start_y", s.sy, start_y);
					compare_field("end_x", s.ex, end_x);
					compare_field("end_y", s.ey, end_y);
					compare_field("last_segment", s.last, last_segment);
				end
			end
			if (start && !busy) predict_cell();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LEVEL:    lvl = longint'(signed'(cfg_data));
					REG_X_ORIGIN: x0 = longint'(signed'(cfg_data));
					REG_Y_TOP:    y0 = longint'(signed'(cfg_data));
					REG_STEP_X:   dx = longint'(cfg_data[STEP_W-1:0]);
					REG_STEP_Y:   dy = longint'(cfg_data[STEP_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	initial failures = 0;

endmodule

FILE: bench/tb_marching_squares_cell_contour_core.sv
// Testbench top: cell stimulus, configuration phases and the verdict.
`timescale 1ns / 100ps
module tb_marching_squares_cell_contour_core;
	import mscc_pkg::*;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    start = 0;
	logic                    busy;
	logic [CELL_W-1:0]       cell_row = '0;
	logic [CELL_W-1:0]       cell_column = '0;
	logic signed [VAL_W-1:0] corner_top_left = '0;
	logic signed [VAL_W-1:0] corner_top_right = '0;
	logic signed [VAL_W-1:0] corner_bottom_right = '0;
	logic signed [VAL_W-1:0] corner_bottom_left = '0;
	logic [3:0]              finite_mask = '0;
	logic                    cfg_valid = 0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [VAL_W-1:0]        cfg_data = '0;
	logic                    strobe;
	logic signed [VAL_W-1:0] start_x, start_y, end_x, end_y;
	logic                    last_segment;
	int                      failures, pending;

	// percentage of cycles the cell source sits idle in the current phase
	int idle_pct;
	// threshold seen by stimulus, kept in step with the level register
	logic signed [VAL_W-1:0] cur_level;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	marching_squares_cell_contour_core dut (.*);

	mscc_segment_checker chk (.*);

	// generous fixed ceiling on the whole run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// one cell transfer; an idle gap may come first
	task automatic send_cell(input logic [CELL_W-1:0] r, input logic [CELL_W-1:0] c,
			input logic signed [VAL_W-1:0] tl, input logic signed [VAL_W-1:0] tr,
			input logic signed [VAL_W-1:0] br, input logic signed [VAL_W-1:0] bl,
			input logic [3:0] m);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		start <= 1;
		cell_row <= r;
		cell_column <= c;
		corner_top_left <= tl;
		corner_top_right <= tr;
		corner_bottom_right <= br;
		corner_bottom_left <= bl;
		finite_mask <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// drain the core until no predicted segment is pending, then let the pipeline
	// settle (cells with no segment are dropped by the front end)
	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == REG_LEVEL) cur_level = val;
	endtask

	task automatic setup(input logic [VAL_W-1:0] lv, input logic [VAL_W-1:0] xo,
			input logic [VAL_W-1:0] yt, input logic [VAL_W-1:0] sx, input logic [VAL_W-1:0] sy);
		settle();
		write_reg(REG_LEVEL, lv);
		write_reg(REG_X_ORIGIN, xo);
		write_reg(REG_Y_TOP, yt);
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		@(posedge clk);
	endtask

	// corner value on the requested side of the threshold, mostly close to it
	function automatic logic signed [VAL_W-1:0] corner_near(input logic above);
		logic signed [VAL_W-1:0] off;
		if ($urandom_range(9) == 0) return $urandom;
		off = $urandom_range(0, 32'h0003_FFFF);
		if ($urandom_range(7) == 0) off = 0;
		return above ? cur_level + off : cur_level - off - 1;
	endfunction

	// mostly well-formed cells with a random case; some masked or off-grid
	task automatic random_cells(input int count);
		logic [3:0] cs, m;
		logic [CELL_W-1:0] r, c;
		for (int i = 0; i < count; i++) begin
			cs = 4'($urandom);
			m = ($urandom_range(9) == 0) ? 4'($urandom) : MASK_ALL;
			r = CELL_W'($urandom_range(0, GRID_SIZE - 2));
			c = CELL_W'($urandom_range(0, GRID_SIZE - 2));
			if ($urandom_range(19) == 0) r = CELL_W'($urandom);
			if ($urandom_range(19) == 0) c = CELL_W'($urandom);
			send_cell(r, c, corner_near(cs[0]), corner_near(cs[1]),
				corner_near(cs[2]), corner_near(cs[3]), m);
		end
	endtask

	function automatic logic signed [VAL_W-1:0] unit_corner(input logic [3:0] cs, input int i);
		return cs[i] ? VAL_W'((i + 1) * 65536) : -VAL_W'((i + 1) * 65536);
	endfunction

	initial begin
		idle_pct = 0;
		cur_level = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset geometry, every case including flats and saddles
		for (int c = 0; c < 16; c++)
			send_cell(CELL_W'(c), CELL_W'(c * 3), unit_corner(4'(c), 0),
				unit_corner(4'(c), 1), unit_corner(4'(c), 2), unit_corner(4'(c), 3),
				MASK_ALL);
		// saddles at the sample extremes
		send_cell(0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, MASK_ALL);
		send_cell(CELL_W'(GRID_SIZE - 2), CELL_W'(GRID_SIZE - 2), 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, MASK_ALL);
		// non-finite corners, off-grid row and column
		send_cell(1, 1, 65536, -65536, -65536, -65536, 4'b1110);
		send_cell(1, 1, 65536, -65536, -65536, -65536, 4'b0111);
		send_cell(1, 1, 65536, -65536, -65536, -65536, 4'b0000);
		send_cell(CELL_W'(GRID_SIZE - 1), 1, 65536, -65536, -65536, -65536, MASK_ALL);
		send_cell(1, CELL_W'(GRID_SIZE - 1), 65536, -65536, -65536, -65536, MASK_ALL);
		random_cells(100);

		// moderate geometry, sender idle most of the time
		setup($urandom_range(0, 32'h0004_0000) - 32'h0002_0000, $urandom, $urandom,
			$urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0010_0000));
		idle_pct = 58;
		random_cells(130);

		// extremes: saturating coordinates, zero step in y
		setup(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		idle_pct = 33;
		send_cell(CELL_W'(GRID_SIZE - 2), CELL_W'(GRID_SIZE - 2), 32'sh80000000, 32'sh7FFFFFFF,
			32'sh80000000, 32'sh7FFFFFFF, MASK_ALL);
		random_cells(130);

		// fully random registers, zero step in x, top level extreme
		setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, $urandom);
		idle_pct = 0;
		send_cell(5, 5, 32'sh7FFFFFFF, 32'sh7FFFFFFE, 32'sh80000000, 32'sh7FFFFFFF, MASK_ALL);
		setup($urandom, $urandom, $urandom, $urandom, $urandom);
		random_cells(130);

		settle();
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
